@@ sv/uart8n1_pkg.sv @@
`timescale 1ns / 1ps
// Package of widths, phase codes, opcodes and register indexes for the 8N1 transceiver.
package uart8n1_pkg;

   localparam int PERIOD_WIDTH   = 20;
   localparam int RX_CNT_WIDTH   = PERIOD_WIDTH + 1;
   localparam int TIMEOUT_WIDTH  = 24;
   localparam int PRESCALE_WIDTH = 10;
   localparam int PHASE_WIDTH    = 4;
   localparam int BYTE_WIDTH     = 8;
   localparam int OP_WIDTH       = 2;
   localparam int APB_ADDR_WIDTH = 3;
   localparam int APB_DATA_WIDTH = 32;

   localparam logic [PERIOD_WIDTH-1:0]   BIT_PERIOD_RESET     = PERIOD_WIDTH'(6076);
   localparam logic [PRESCALE_WIDTH-1:0] TICKS_PER_USEC_RESET = PRESCALE_WIDTH'(1);

   localparam logic [OP_WIDTH-1:0] OP_TICK = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SEND = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_RECV = 2'd2;

   localparam logic CSR_BIT_PERIOD     = 1'b0;
   localparam logic CSR_TICKS_PER_USEC = 1'b1;

   localparam logic [PHASE_WIDTH-1:0] TX_IDLE       = 4'd0;
   localparam logic [PHASE_WIDTH-1:0] TX_START      = 4'd1;
   localparam logic [PHASE_WIDTH-1:0] TX_DATA_FIRST = 4'd2;
   localparam logic [PHASE_WIDTH-1:0] TX_DATA_LAST  = 4'd9;
   localparam logic [PHASE_WIDTH-1:0] TX_STOP       = 4'd10;

   localparam logic [PHASE_WIDTH-1:0] RX_IDLE         = 4'd0;
   localparam logic [PHASE_WIDTH-1:0] RX_WAIT_START   = 4'd1;
   localparam logic [PHASE_WIDTH-1:0] RX_SAMPLE_FIRST = 4'd2;
   localparam logic [PHASE_WIDTH-1:0] RX_SAMPLE_LAST  = 4'd9;
   localparam logic [PHASE_WIDTH-1:0] RX_HALF_BIT     = 4'd10;
   localparam logic [PHASE_WIDTH-1:0] RX_WAIT_HIGH    = 4'd11;

endpackage

@@ sv/uart8n1_transceiver_top.sv @@
`timescale 1ns / 1ps
// Top level of the bit-timed 8N1 serial transmitter and receiver.
//
// Every request transaction is one tick of the serial bit timing and yields exactly one
// response transaction. The block takes one request per clock cycle: the transmitter and
// receiver state advance in the cycle a request is accepted and the response is held in an
// output register, so a request is taken whenever that register is empty or being drained.
// The transmitter sends a low start bit, eight data bits LSB first and a high stop bit, each
// bit_period ticks long. The receiver waits up to req_wait_us microseconds (ticks_per_usec
// ticks each) for a low start level, samples at 1.5 bit periods and every bit period after,
// waits half a bit, then waits for a high level and reports the byte. A busy side ignores
// its start command. The registers are bit_period at byte address 0 and ticks_per_usec at
// byte address 4.
module uart_8n1_transceiver_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [uart8n1_pkg::OP_WIDTH-1:0]       req_opcode,
   input  logic [uart8n1_pkg::BYTE_WIDTH-1:0]     req_tx_byte,
   input  logic [uart8n1_pkg::TIMEOUT_WIDTH-1:0]  req_wait_us,
   input  logic                                   req_rx_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_tx_line,
   output logic                                   rsp_tx_busy,
   output logic                                   rsp_rx_busy,
   output logic                                   rsp_rx_done,
   output logic                                   rsp_rx_timed_out,
   output logic [uart8n1_pkg::BYTE_WIDTH-1:0]     rsp_rx_byte,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [uart8n1_pkg::APB_ADDR_WIDTH-1:0] paddr,
   input  logic [uart8n1_pkg::APB_DATA_WIDTH-1:0] pwdata,
   output logic [uart8n1_pkg::APB_DATA_WIDTH-1:0] prdata,
   output logic                                   pready
);

   logic [uart8n1_pkg::PERIOD_WIDTH-1:0]   bit_period_ff;
   logic [uart8n1_pkg::PRESCALE_WIDTH-1:0] ticks_per_usec_ff;

   logic [uart8n1_pkg::PHASE_WIDTH-1:0]    tx_phase_ff, tx_phase_in;
   logic [uart8n1_pkg::BYTE_WIDTH-1:0]     tx_shift_ff, tx_shift_in;
   logic [uart8n1_pkg::PERIOD_WIDTH-1:0]   tx_count_ff, tx_count_in;
   logic [uart8n1_pkg::PHASE_WIDTH-1:0]    rx_phase_ff, rx_phase_in;
   logic [uart8n1_pkg::BYTE_WIDTH-1:0]     rx_shift_ff, rx_shift_in;
   logic [uart8n1_pkg::RX_CNT_WIDTH-1:0]   rx_count_ff, rx_count_in;
   logic [uart8n1_pkg::PRESCALE_WIDTH-1:0] usec_prescale_ff, usec_prescale_in;
   logic [uart8n1_pkg::TIMEOUT_WIDTH-1:0]  usec_elapsed_ff, usec_elapsed_in;
   logic [uart8n1_pkg::TIMEOUT_WIDTH-1:0]  timeout_limit_ff, timeout_limit_in;

   logic                                   rsp_valid_ff;
   logic                                   rsp_tx_line_ff, rsp_tx_line_in;
   logic                                   rsp_tx_busy_ff, rsp_tx_busy_in;
   logic                                   rsp_rx_busy_ff, rsp_rx_busy_in;
   logic                                   rsp_rx_done_ff, rsp_rx_done_in;
   logic                                   rsp_rx_timed_out_ff, rsp_rx_timed_out_in;
   logic [uart8n1_pkg::BYTE_WIDTH-1:0]     rsp_rx_byte_ff, rsp_rx_byte_in;

   logic                                   req_accept;
   logic                                   csr_write;
   logic                                   csr_index;
   logic [uart8n1_pkg::PERIOD_WIDTH-1:0]   half_period;
   logic [uart8n1_pkg::RX_CNT_WIDTH-1:0]   first_wait;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign pready     = 1'b1;
   assign csr_index  = paddr[2];
   assign csr_write  = psel && penable && pwrite && pready;

   assign half_period = bit_period_ff >> 1;
   assign first_wait  = {1'b0, bit_period_ff} + {1'b0, half_period};

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff     <= uart8n1_pkg::BIT_PERIOD_RESET;
         ticks_per_usec_ff <= uart8n1_pkg::TICKS_PER_USEC_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            uart8n1_pkg::CSR_BIT_PERIOD: begin
               bit_period_ff <= pwdata[uart8n1_pkg::PERIOD_WIDTH-1:0];
            end
            uart8n1_pkg::CSR_TICKS_PER_USEC: begin
               ticks_per_usec_ff <= pwdata[uart8n1_pkg::PRESCALE_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         uart8n1_pkg::CSR_BIT_PERIOD: begin
            prdata = uart8n1_pkg::APB_DATA_WIDTH'(bit_period_ff);
         end
         uart8n1_pkg::CSR_TICKS_PER_USEC: begin
            prdata = uart8n1_pkg::APB_DATA_WIDTH'(ticks_per_usec_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // transmitter
   always_comb begin
      logic [uart8n1_pkg::PHASE_WIDTH-1:0]  ph;
      logic [uart8n1_pkg::BYTE_WIDTH-1:0]   sh;
      logic [uart8n1_pkg::PERIOD_WIDTH-1:0] cnt;
      ph             = tx_phase_ff;
      sh             = tx_shift_ff;
      cnt            = tx_count_ff;
      rsp_tx_line_in = 1'b1;
      rsp_tx_busy_in = 1'b0;
      if (req_opcode == uart8n1_pkg::OP_SEND && ph == uart8n1_pkg::TX_IDLE) begin
         ph  = uart8n1_pkg::TX_START;
         sh  = req_tx_byte;
         cnt = '0;
      end
      unique case (ph) inside
         uart8n1_pkg::TX_START,
         [uart8n1_pkg::TX_DATA_FIRST:uart8n1_pkg::TX_DATA_LAST],
         uart8n1_pkg::TX_STOP: begin
            rsp_tx_busy_in = 1'b1;
            if (ph == uart8n1_pkg::TX_START) begin
               rsp_tx_line_in = 1'b0;
            end else if (ph != uart8n1_pkg::TX_STOP) begin
               rsp_tx_line_in = sh[0];
            end
            cnt = cnt + 1'b1;
            if (cnt >= bit_period_ff) begin
               cnt = '0;
               if (ph != uart8n1_pkg::TX_START && ph != uart8n1_pkg::TX_STOP) begin
                  sh = sh >> 1;
               end
               ph = (ph == uart8n1_pkg::TX_STOP) ? uart8n1_pkg::TX_IDLE : ph + 1'b1;
            end
         end
         default: begin
            ph = uart8n1_pkg::TX_IDLE;
         end
      endcase
      tx_phase_in = ph;
      tx_shift_in = sh;
      tx_count_in = cnt;
   end

   // receiver
   always_comb begin
      logic [uart8n1_pkg::PHASE_WIDTH-1:0]    ph;
      logic [uart8n1_pkg::BYTE_WIDTH-1:0]     sh;
      logic [uart8n1_pkg::RX_CNT_WIDTH-1:0]   cnt;
      logic [uart8n1_pkg::PRESCALE_WIDTH-1:0] pre;
      logic [uart8n1_pkg::TIMEOUT_WIDTH-1:0]  elapsed;
      logic [uart8n1_pkg::TIMEOUT_WIDTH-1:0]  limit;
      logic [uart8n1_pkg::RX_CNT_WIDTH-1:0]   wait_len;
      logic                                   check;
      ph                  = rx_phase_ff;
      sh                  = rx_shift_ff;
      cnt                 = rx_count_ff;
      pre                 = usec_prescale_ff;
      elapsed             = usec_elapsed_ff;
      limit               = timeout_limit_ff;
      wait_len            = first_wait;
      check               = 1'b0;
      rsp_rx_busy_in      = 1'b0;
      rsp_rx_done_in      = 1'b0;
      rsp_rx_timed_out_in = 1'b0;
      rsp_rx_byte_in      = '0;
      if (req_opcode == uart8n1_pkg::OP_RECV && ph == uart8n1_pkg::RX_IDLE) begin
         ph      = uart8n1_pkg::RX_WAIT_START;
         limit   = req_wait_us;
         elapsed = '0;
         pre     = '0;
         sh      = '0;
         cnt     = '0;
      end
      unique case (ph) inside
         uart8n1_pkg::RX_WAIT_START: begin
            rsp_rx_busy_in = 1'b1;
            if (!req_rx_level) begin
               ph  = uart8n1_pkg::RX_SAMPLE_FIRST;
               cnt = '0;
            end else if (elapsed >= limit) begin
               rsp_rx_timed_out_in = 1'b1;
               ph                  = uart8n1_pkg::RX_IDLE;
            end else begin
               pre = pre + 1'b1;
               if (pre >= ticks_per_usec_ff) begin
                  pre = '0;
                  if (elapsed != '1) begin
                     elapsed = elapsed + 1'b1;
                  end
               end
            end
         end
         [uart8n1_pkg::RX_SAMPLE_FIRST:uart8n1_pkg::RX_SAMPLE_LAST]: begin
            rsp_rx_busy_in = 1'b1;
            if (ph != uart8n1_pkg::RX_SAMPLE_FIRST) begin
               wait_len = {1'b0, bit_period_ff};
            end
            cnt = cnt + 1'b1;
            if (cnt >= wait_len) begin
               cnt = '0;
               sh  = {req_rx_level, sh[uart8n1_pkg::BYTE_WIDTH-1:1]};
               ph  = ph + 1'b1;
            end
         end
         uart8n1_pkg::RX_HALF_BIT,
         uart8n1_pkg::RX_WAIT_HIGH: begin
            rsp_rx_busy_in = 1'b1;
            check          = (ph == uart8n1_pkg::RX_WAIT_HIGH);
            if (ph == uart8n1_pkg::RX_HALF_BIT) begin
               cnt = cnt + 1'b1;
               if (cnt >= {1'b0, half_period}) begin
                  cnt   = '0;
                  ph    = uart8n1_pkg::RX_WAIT_HIGH;
                  check = 1'b1;
               end
            end
            if (check && req_rx_level) begin
               rsp_rx_done_in = 1'b1;
               rsp_rx_byte_in = sh;
               ph             = uart8n1_pkg::RX_IDLE;
            end
         end
         default: begin
            ph = uart8n1_pkg::RX_IDLE;
         end
      endcase
      rx_phase_in      = ph;
      rx_shift_in      = sh;
      rx_count_in      = cnt;
      usec_prescale_in = pre;
      usec_elapsed_in  = elapsed;
      timeout_limit_in = limit;
   end

   // advance state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_phase_ff      <= uart8n1_pkg::TX_IDLE;
         tx_shift_ff      <= '0;
         tx_count_ff      <= '0;
         rx_phase_ff      <= uart8n1_pkg::RX_IDLE;
         rx_shift_ff      <= '0;
         rx_count_ff      <= '0;
         usec_prescale_ff <= '0;
         usec_elapsed_ff  <= '0;
         timeout_limit_ff <= '0;
      end else if (req_accept) begin
         tx_phase_ff      <= tx_phase_in;
         tx_shift_ff      <= tx_shift_in;
         tx_count_ff      <= tx_count_in;
         rx_phase_ff      <= rx_phase_in;
         rx_shift_ff      <= rx_shift_in;
         rx_count_ff      <= rx_count_in;
         usec_prescale_ff <= usec_prescale_in;
         usec_elapsed_ff  <= usec_elapsed_in;
         timeout_limit_ff <= timeout_limit_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tx_line_ff      <= rsp_tx_line_in;
         rsp_tx_busy_ff      <= rsp_tx_busy_in;
         rsp_rx_busy_ff      <= rsp_rx_busy_in;
         rsp_rx_done_ff      <= rsp_rx_done_in;
         rsp_rx_timed_out_ff <= rsp_rx_timed_out_in;
         rsp_rx_byte_ff      <= rsp_rx_byte_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_line      = rsp_tx_line_ff;
   assign rsp_tx_busy      = rsp_tx_busy_ff;
   assign rsp_rx_busy      = rsp_rx_busy_ff;
   assign rsp_rx_done      = rsp_rx_done_ff;
   assign rsp_rx_timed_out = rsp_rx_timed_out_ff;
   assign rsp_rx_byte      = rsp_rx_byte_ff;

   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

   a_done_xor_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_rx_done_ff && rsp_rx_timed_out_ff))
      else $error("receive reported both completion and timeout");

   a_rx_report_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_rx_done_ff || rsp_rx_timed_out_ff) |-> rsp_rx_busy_ff)
      else $error("receive report without busy receiver");

   a_tx_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tx_busy_ff |-> rsp_tx_line_ff)
      else $error("transmit line low while transmitter idle");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      tx_phase_ff <= uart8n1_pkg::TX_STOP && rx_phase_ff <= uart8n1_pkg::RX_WAIT_HIGH)
      else $error("phase register outside its sequence");

endmodule
